[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. The checks vanish when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`endif

`endif

[design/pse_pkg.sv]
// ----------------------------------------------------------------------------
// pse_pkg
// Types and codes shared by the postfix stack evaluator and its divider.
// ----------------------------------------------------------------------------
package pse_pkg;

	// Data path and field widths.
	localparam int DATA_W          = 32;
	localparam int CMD_W           = 3;
	localparam int STATUS_W        = 2;
	localparam int DEPTH_W         = 7;
	localparam int STACK_DEPTH_DEF = 64;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ADD  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SUB  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_MUL  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DIV  = 3'd5;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVER    = 2'd3;

	// One command beat.
	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic signed [DATA_W-1:0] push_value;
	} pse_cmd_t;

	// One result beat.
	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] top_value;
		logic [DEPTH_W-1:0]       depth;
	} pse_res_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_WB,
		S_REFILL
	} pse_state_t;

endpackage

[design/pse_div.sv]
// ----------------------------------------------------------------------------
// pse_div
// Signed 32-bit divider, truncating toward zero. Restoring algorithm, one
// quotient bit per cycle; the quotient appears with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module pse_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [pse_pkg::DATA_W-1:0]    dividend,
	input  logic [pse_pkg::DATA_W-1:0]    divisor,
	output logic                          done,
	output logic [pse_pkg::DATA_W-1:0]    quotient
);

	localparam int W     = pse_pkg::DATA_W;
	localparam int CNT_W = $clog2(W + 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(W);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [W:0]       rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dvs_q;
	logic [W-1:0]     quotient_q;

	logic [W:0]       rem_shift;
	logic [W:0]       diff;

	// One trial subtraction of the shifted remainder.
	always_comb begin
		rem_shift = {rem_q[W-1:0], quo_q[W-1]};
		diff      = rem_shift - {1'b0, dvs_q};
	end

	// Control: iteration count and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// Data path: magnitudes on start, one bit a cycle, sign fix at the end.
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend[W-1] ? (W'(0) - dividend) : dividend;
			dvs_q <= divisor[W-1] ? (W'(0) - divisor) : divisor;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (run_q) begin
			if (cnt_q == LAST) begin
				quotient_q <= neg_q ? (W'(0) - quo_q) : quo_q;
			end else if (!diff[W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quotient_q;

endmodule

[design/postfix_stack_evaluator.sv]
// Sequence: push, unused codes and underflow end in S_IDLE on the start beat; pop ends in
// S_IDLE or S_REFILL; add, subtract and multiply pass S_LOAD and S_WB; divide passes S_LOAD,
// S_DIV and S_WB; divide by zero ends in S_LOAD or S_REFILL. One command at a time, taken in
// S_IDLE; busy drops in the cycle done is shown; the bit-serial 32-step divider is slowest.
// Reset: arst_n clears the depth, cached top and sequencer at once; the stack memory is not
// cleared, and no entry at or above the depth is ever read.
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// RPN evaluator over a bounded stack of signed 32-bit integers held in a
// synchronous memory, with a cached copy of the top entry.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  pse_pkg::pse_cmd_t  cmd,
	output logic               done,
	output pse_pkg::pse_res_t  result
);

	localparam int W  = pse_pkg::DATA_W;
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

	// Stack memory with registered read data.
	logic [W-1:0] mem [STACK_DEPTH];
	logic [W-1:0] rdata_q;
	logic         rd_en;
	logic [AW-1:0] rd_addr;
	logic         wr_en;
	logic [AW-1:0] wr_addr;
	logic [W-1:0] wr_data;

	// Sequencer and stack bookkeeping.
	pse_pkg::pse_state_t state_q, state_d;
	logic [DW-1:0]               depth_q, depth_d;
	logic [W-1:0]                top_q, top_d;
	logic [pse_pkg::CMD_W-1:0]   cmd_q, cmd_d;
	logic                        hold_q, hold_d;
	logic [W-1:0]                held_q, held_d;
	logic [pse_pkg::STATUS_W-1:0] status_q, status_d;
	logic [W-1:0]                res_q, res_d;
	logic                        res_en;

	// Result beat.
	logic                         fin;
	logic [pse_pkg::STATUS_W-1:0] fin_status;
	logic [W-1:0]                 fin_top;
	logic                         done_q;
	pse_pkg::pse_res_t            result_q;
	logic [DW+pse_pkg::DEPTH_W-1:0] depth_ext;

	// Divider hookup.
	logic         div_go;
	logic         div_done;
	logic [W-1:0] div_quo;

	logic [DW-1:0] dm1, dm2, dm3, dp1;

	assign dm1 = depth_q - DW'(1);
	assign dm2 = depth_q - DW'(2);
	assign dm3 = depth_q - DW'(3);
	assign dp1 = depth_q + DW'(1);
	assign depth_ext = {{pse_pkg::DEPTH_W{1'b0}}, depth_d};

	pse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (rdata_q),
		.divisor  (top_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Stack memory: one write and one read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Next state, memory accesses and the result of each command.
	always_comb begin
		state_d    = state_q;
		depth_d    = depth_q;
		top_d      = top_q;
		cmd_d      = cmd_q;
		hold_d     = hold_q;
		held_d     = held_q;
		status_d   = status_q;
		res_d      = res_q;
		res_en     = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = dm2[AW-1:0];
		wr_en      = 1'b0;
		wr_addr    = depth_q[AW-1:0];
		wr_data    = cmd.push_value;
		div_go     = 1'b0;
		fin        = 1'b0;
		fin_status = pse_pkg::ST_OK;
		fin_top    = top_q;
		case (state_q)
			pse_pkg::S_IDLE: begin
				if (start) begin
					cmd_d = cmd.command;
					case (cmd.command)
						pse_pkg::CMD_PUSH: begin
							fin = 1'b1;
							if (depth_q == FULL) begin
								fin_status = pse_pkg::ST_OVER;
							end else begin
								wr_en   = 1'b1;
								depth_d = dp1;
								top_d   = cmd.push_value;
								fin_top = cmd.push_value;
							end
						end
						pse_pkg::CMD_POP: begin
							if (depth_q == '0) begin
								fin        = 1'b1;
								fin_status = pse_pkg::ST_UNDER;
								fin_top    = '0;
							end else if (depth_q == DW'(1)) begin
								fin     = 1'b1;
								depth_d = '0;
								top_d   = '0;
							end else begin
								// The popped value answers; the new top comes from memory.
								depth_d  = dm1;
								hold_d   = 1'b1;
								held_d   = top_q;
								status_d = pse_pkg::ST_OK;
								rd_en    = 1'b1;
								state_d  = pse_pkg::S_REFILL;
							end
						end
						pse_pkg::CMD_ADD, pse_pkg::CMD_SUB,
						pse_pkg::CMD_MUL, pse_pkg::CMD_DIV: begin
							if (depth_q == '0) begin
								fin        = 1'b1;
								fin_status = pse_pkg::ST_UNDER;
								fin_top    = '0;
							end else if (depth_q == DW'(1)) begin
								// The lone right operand stays popped.
								fin        = 1'b1;
								fin_status = pse_pkg::ST_UNDER;
								fin_top    = '0;
								depth_d    = '0;
								top_d      = '0;
							end else begin
								rd_en   = 1'b1;
								state_d = pse_pkg::S_LOAD;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			pse_pkg::S_LOAD: begin
				// Left operand is in rdata_q, right operand is the cached top.
				case (cmd_q)
					pse_pkg::CMD_ADD: begin
						res_d   = rdata_q + top_q;
						res_en  = 1'b1;
						state_d = pse_pkg::S_WB;
					end
					pse_pkg::CMD_SUB: begin
						res_d   = rdata_q - top_q;
						res_en  = 1'b1;
						state_d = pse_pkg::S_WB;
					end
					pse_pkg::CMD_MUL: begin
						res_d   = rdata_q * top_q;
						res_en  = 1'b1;
						state_d = pse_pkg::S_WB;
					end
					pse_pkg::CMD_DIV: begin
						if (top_q == '0) begin
							depth_d  = dm2;
							status_d = pse_pkg::ST_DIVZERO;
							hold_d   = 1'b0;
							if (depth_q > DW'(2)) begin
								rd_en   = 1'b1;
								rd_addr = dm3[AW-1:0];
								state_d = pse_pkg::S_REFILL;
							end else begin
								top_d      = '0;
								fin        = 1'b1;
								fin_status = pse_pkg::ST_DIVZERO;
								fin_top    = '0;
								state_d    = pse_pkg::S_IDLE;
							end
						end else begin
							div_go  = 1'b1;
							state_d = pse_pkg::S_DIV;
						end
					end
					default: begin
						state_d = pse_pkg::S_IDLE;
					end
				endcase
			end
			pse_pkg::S_DIV: begin
				if (div_done) begin
					res_d   = div_quo;
					res_en  = 1'b1;
					state_d = pse_pkg::S_WB;
				end
			end
			pse_pkg::S_WB: begin
				// Both operands gone, the result takes the left operand's slot.
				wr_en   = 1'b1;
				wr_addr = dm2[AW-1:0];
				wr_data = res_q;
				depth_d = dm1;
				top_d   = res_q;
				fin     = 1'b1;
				fin_top = res_q;
				state_d = pse_pkg::S_IDLE;
			end
			pse_pkg::S_REFILL: begin
				top_d      = rdata_q;
				fin        = 1'b1;
				fin_status = status_q;
				fin_top    = hold_q ? held_q : rdata_q;
				state_d    = pse_pkg::S_IDLE;
			end
			default: begin
				state_d = pse_pkg::S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pse_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Stack bookkeeping and the done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			top_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			depth_q <= depth_d;
			top_q   <= top_d;
			done_q  <= fin;
		end
	end

	// Payload registers held across a command.
	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		hold_q   <= hold_d;
		held_q   <= held_d;
		status_q <= status_d;
		if (res_en) begin
			res_q <= res_d;
		end
		if (fin) begin
			result_q.status    <= fin_status;
			result_q.top_value <= fin_top;
			result_q.depth     <= depth_ext[pse_pkg::DEPTH_W-1:0];
		end
	end

	assign busy   = (state_q != pse_pkg::S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// A result beat only follows an accepted command or work in progress.
	`ASSERT_IMPLIES(a_done_follows_work, clk, arst_n, done, $past(busy || start))
	// The entry count never passes the stack size.
	`ASSERT_ALWAYS(a_depth_bounded, clk, arst_n, depth_q <= FULL)
	// The depth moves only while a command is taken or worked on.
	`ASSERT_IMPLIES(a_depth_quiet, clk, arst_n, !$past(busy) && !$past(start), $stable(depth_q))

endmodule
